>>> rtl/psg_pkg.sv
// Shared types, constants and the attenuation table of the sound generator.
// Used by every module of the block; depends on nothing.
package psg_pkg;

	// Number of tone period registers that always exist and can be written.
	localparam int TONE_REGS = 3;
	// Depth of the command queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [7:0] SPACING_RESET = 8'd81;
	localparam logic [7:0] MIN_SPACING = 8'd64;
	localparam logic [15:0] NOISE_SEED = 16'h8000;
	localparam logic [7:0] NOISE_RATE_0 = 8'h10;
	localparam logic [7:0] NOISE_RATE_1 = 8'h20;
	localparam logic [7:0] NOISE_RATE_2 = 8'h40;
	localparam logic [1:0] NOISE_CHAN = 2'd3;
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	// Commands passed from the front to the back part.
	typedef enum logic [2:0] {
		OP_TONE_LO,
		OP_TONE_HI,
		OP_ATTEN,
		OP_NOISE,
		OP_SAMPLE
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] chan;
		logic [5:0] data;
		logic       last;
	} cmd_t;

	typedef enum logic {
		F_IDLE,
		F_EMIT
	} front_state_t;

	typedef enum logic {
		B_IDLE,
		B_MIX
	} back_state_t;

	// Amplitude for each attenuation level: 2 dB steps, the top level is silent.
	function automatic logic [14:0] amp_level(input logic [3:0] lvl);
		logic [14:0] amp;
		unique case (lvl)
			4'd0:    amp = 15'd32767;
			4'd1:    amp = 15'd26027;
			4'd2:    amp = 15'd20674;
			4'd3:    amp = 15'd16422;
			4'd4:    amp = 15'd13044;
			4'd5:    amp = 15'd10361;
			4'd6:    amp = 15'd8230;
			4'd7:    amp = 15'd6537;
			4'd8:    amp = 15'd5193;
			4'd9:    amp = 15'd4125;
			4'd10:   amp = 15'd3276;
			4'd11:   amp = 15'd2602;
			4'd12:   amp = 15'd2067;
			4'd13:   amp = 15'd1642;
			4'd14:   amp = 15'd1304;
			default: amp = 15'd0;
		endcase
		return amp;
	endfunction

endpackage

>>> rtl/psg_front.sv
// Front part: takes input beats, decodes port bytes into register commands and
// splits ticks into one sample command per due sample. Depends on psg_pkg.
module psg_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [7:0]        write_value,
	input  logic [7:0]        cycles,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        sample_spacing,
	input  logic              q_full,
	output logic              q_push,
	output psg_pkg::cmd_t     q_cmd,
	output logic              busy
);
	import psg_pkg::*;

	front_state_t state_q, state_d;
	logic [7:0] spacing_cfg_q;
	logic [8:0] acc_q;
	logic [2:0] latch_target_q;
	logic       latch_seen_q;

	logic [8:0] spacing;
	logic [8:0] acc_rem;
	logic       due;
	logic       more;
	logic       accept;
	logic [2:0] target;
	logic       wr_ok;
	cmd_t       wr_cmd;
	cmd_t       smp_cmd;

	// Effective sample spacing, never below the minimum.
	always_comb begin
		spacing = (spacing_cfg_q < MIN_SPACING) ? {1'b0, MIN_SPACING} : {1'b0, spacing_cfg_q};
		acc_rem = acc_q - spacing;
		due     = acc_q >= spacing;
		more    = acc_rem >= spacing;
		accept  = in_valid && in_ready;
	end

	// Latch/data byte decoding into a register command.
	always_comb begin
		target = write_value[7] ? write_value[6:4] : latch_target_q;
		wr_ok  = write_value[7] || latch_seen_q;
		wr_cmd = '{op: OP_TONE_LO, chan: target[2:1], data: {2'b00, write_value[3:0]}, last: 1'b0};
		if (target[0]) begin
			wr_cmd.op = OP_ATTEN;
		end else if (target[2:1] == NOISE_CHAN) begin
			wr_cmd.op   = OP_NOISE;
			wr_cmd.data = {3'b000, write_value[2:0]};
		end else if (!write_value[7]) begin
			wr_cmd.op   = OP_TONE_HI;
			wr_cmd.data = write_value[5:0];
		end
		smp_cmd = '{op: OP_SAMPLE, chan: 2'd0, data: 6'd0, last: !more};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept && req_type == REQ_TICK) state_d = F_EMIT;
			F_EMIT: if (!due) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// Handshake and queue outputs.
	always_comb begin
		cfg_ready = 1'b1;
		in_ready  = 1'b0;
		q_push    = 1'b0;
		q_cmd     = wr_cmd;
		busy      = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = !q_full;
				q_push   = accept && req_type == REQ_WRITE && wr_ok;
			end
			F_EMIT: begin
				busy   = 1'b1;
				q_push = due && !q_full;
				q_cmd  = smp_cmd;
			end
			default: ;
		endcase
	end

	// State, accumulator, latch and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= F_IDLE;
			spacing_cfg_q  <= SPACING_RESET;
			acc_q          <= 9'd0;
			latch_target_q <= 3'd0;
			latch_seen_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				spacing_cfg_q <= sample_spacing;
			end
			if (accept && req_type == REQ_TICK) begin
				acc_q <= acc_q + {1'b0, cycles};
			end else if (state_q == F_EMIT && due && !q_full) begin
				acc_q <= acc_rem;
			end
			if (accept && req_type == REQ_WRITE && write_value[7]) begin
				latch_target_q <= write_value[6:4];
				latch_seen_q   <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/psg_cmd_queue.sv
// Short first-in first-out queue of commands between front and back parts.
// Depends on psg_pkg for the command type and depth.
module psg_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  psg_pkg::cmd_t push_cmd,
	input  logic          pop,
	output psg_pkg::cmd_t head_cmd,
	output logic          empty,
	output logic          full
);
	import psg_pkg::*;

	cmd_t            slot_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   count_q;
	logic            do_push;
	logic            do_pop;

	// Status and read side.
	always_comb begin
		empty    = count_q == '0;
		full     = count_q == (Q_AW+1)'(Q_DEPTH);
		do_push  = push && !full;
		do_pop   = pop && !empty;
		head_cmd = slot_q[rd_ptr_q];
	end

	// Storage, no reset needed.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/psg_back.sv
// Back part: holds the sound registers, applies register commands, steps the
// tone and noise generators and mixes one sample per sample command. Uses psg_pkg.
module psg_back #(
	parameter int TONE_CHANNELS = 3
) (
	input  logic          clk,
	input  logic          arst_n,
	input  psg_pkg::cmd_t head_cmd,
	input  logic          q_empty,
	output logic          q_pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [14:0]   sample,
	output logic          last
);
	import psg_pkg::*;

	back_state_t state_q, state_d;
	logic [9:0]  tone_period_q [TONE_REGS];
	logic [9:0]  tone_count_q [TONE_CHANNELS];
	logic        tone_level_q [TONE_CHANNELS];
	logic [3:0]  atten_q [4];
	logic [2:0]  noise_ctrl_q;
	logic [7:0]  noise_count_q;
	logic [15:0] noise_shift_q;
	logic        noise_level_q;
	logic        pend_last_q;
	logic        out_valid_q;
	logic [14:0] sample_q;
	logic        last_q;

	logic        load_out;
	logic [9:0]  tone_cnt_nx [TONE_CHANNELS];
	logic        tone_wrap [TONE_CHANNELS];
	logic [9:0]  tone_per;
	logic [7:0]  noise_per;
	logic [7:0]  noise_cnt_nx;
	logic        noise_wrap;
	logic        noise_fb;
	logic [16:0] mix_sum;

	// Tone counters: count up, clear and toggle on reaching the period.
	always_comb begin
		for (int i = 0; i < TONE_CHANNELS; i++) begin
			tone_per       = (tone_period_q[i] == 10'd0) ? 10'd1 : tone_period_q[i];
			tone_cnt_nx[i] = tone_count_q[i] + 10'd1;
			tone_wrap[i]   = tone_cnt_nx[i] >= tone_per;
		end
	end

	// Noise rate selection and feedback.
	always_comb begin
		unique case (noise_ctrl_q[1:0])
			2'd0:    noise_per = NOISE_RATE_0;
			2'd1:    noise_per = NOISE_RATE_1;
			2'd2:    noise_per = NOISE_RATE_2;
			default: noise_per = tone_period_q[2][7:0];
		endcase
		if (noise_per == 8'd0) noise_per = 8'd1;
		noise_cnt_nx = noise_count_q + 8'd1;
		noise_wrap   = noise_cnt_nx >= noise_per;
		noise_fb     = noise_ctrl_q[2] ? (noise_shift_q[0] ^ noise_shift_q[3]) : noise_shift_q[0];
	end

	// Mixer: sum of the amplitudes of the channels whose level is high.
	always_comb begin
		mix_sum = noise_level_q ? {2'b00, amp_level(atten_q[3])} : 17'd0;
		for (int i = 0; i < TONE_CHANNELS; i++) begin
			if (tone_level_q[i]) mix_sum = mix_sum + {2'b00, amp_level(atten_q[i])};
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (!q_empty && head_cmd.op == OP_SAMPLE) state_d = B_MIX;
			B_MIX:  if (!out_valid_q || out_ready) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Queue pop and output load.
	always_comb begin
		q_pop    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			B_IDLE:  q_pop = !q_empty;
			B_MIX:   load_out = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// Sound registers and generators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= B_IDLE;
			for (int i = 0; i < TONE_REGS; i++) tone_period_q[i] <= 10'd0;
			for (int i = 0; i < TONE_CHANNELS; i++) begin
				tone_count_q[i] <= 10'd0;
				tone_level_q[i] <= 1'b0;
			end
			for (int i = 0; i < 4; i++) atten_q[i] <= 4'd0;
			noise_ctrl_q  <= 3'd0;
			noise_count_q <= 8'd0;
			noise_shift_q <= NOISE_SEED;
			noise_level_q <= 1'b0;
			pend_last_q   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (q_pop) begin
				unique case (head_cmd.op)
					OP_TONE_LO: begin
						for (int i = 0; i < TONE_REGS; i++) begin
							if (head_cmd.chan == 2'(i)) begin
								tone_period_q[i][3:0] <= head_cmd.data[3:0];
							end
						end
					end
					OP_TONE_HI: begin
						for (int i = 0; i < TONE_REGS; i++) begin
							if (head_cmd.chan == 2'(i)) begin
								tone_period_q[i][9:4] <= head_cmd.data;
							end
						end
					end
					OP_ATTEN: atten_q[head_cmd.chan] <= head_cmd.data[3:0];
					OP_NOISE: begin
						noise_ctrl_q  <= head_cmd.data[2:0];
						noise_shift_q <= NOISE_SEED;
					end
					OP_SAMPLE: begin
						pend_last_q <= head_cmd.last;
						for (int i = 0; i < TONE_CHANNELS; i++) begin
							if (tone_wrap[i]) begin
								tone_count_q[i] <= 10'd0;
								tone_level_q[i] <= !tone_level_q[i];
							end else begin
								tone_count_q[i] <= tone_cnt_nx[i];
							end
						end
						if (noise_wrap) begin
							noise_count_q <= 8'd0;
							noise_shift_q <= {noise_fb, noise_shift_q[15:1]};
							noise_level_q <= noise_shift_q[1];
						end else begin
							noise_count_q <= noise_cnt_nx;
						end
					end
					default: ;
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (load_out) begin
			sample_q <= mix_sum[16:2];
			last_q   <= pend_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign last      = last_q;

endmodule

>>> rtl/square_noise_sound_generator_top.sv
// Four-channel square and noise sound generator: front decoder, command queue
// and back generator. A port write is decoded into at most one command; an accepted
// tick makes the front emit one sample command per due sample while the queue has room, then return idle.
// In the back each sample is stepped, then mixed into the output register; no new
// command is taken while it mixes, and the mix waits while the output is not taken.
// Reset is asynchronous, active low: control registers clear, noise seed loads, spacing is 81.
module square_noise_sound_generator_top #(
	parameter int TONE_CHANNELS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [7:0]  write_value,
	input  logic [7:0]  cycles,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] sample,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  sample_spacing
);
	import psg_pkg::*;

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	logic busy;
	cmd_t push_cmd;
	cmd_t head_cmd;

	psg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.req_type       (req_type),
		.write_value    (write_value),
		.cycles         (cycles),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.sample_spacing (sample_spacing),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_cmd          (push_cmd),
		.busy           (busy)
	);

	psg_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (push_cmd),
		.pop      (q_pop),
		.head_cmd (head_cmd),
		.empty    (q_empty),
		.full     (q_full)
	);

	psg_back #(
		.TONE_CHANNELS (TONE_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_cmd  (head_cmd),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.last      (last)
	);

	// The front never pushes into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("command pushed into full queue");

	// The back never pops an empty queue.
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_empty))
		else $error("command popped from empty queue");

	// A sample that is not the last of its tick keeps the front emitting.
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && push_cmd.op == OP_SAMPLE && !push_cmd.last) |=> busy)
		else $error("front stopped before the last sample of a tick");

	// No new input beat is taken while the front still splits a tick.
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("input taken while tick in progress");

endmodule
